// ----- hdl/serial_bank_mapper_mmc1_defines.svh -----
// ---------------------------------------------------------------------------
// Serial bank mapper assertion macros
// Checks are compiled for simulation and removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef SERIAL_BANK_MAPPER_MMC1_DEFINES_SVH
`define SERIAL_BANK_MAPPER_MMC1_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define SBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbm check failed");

// Check a property on every clock edge, reset included.
`define SBM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sbm reset check failed");

`else

`define SBM_ASSERT(lbl, prop)
`define SBM_ASSERT_RST(lbl, prop)

`endif

`endif

// ----- hdl/sbm_pkg.sv -----
// ---------------------------------------------------------------------------
// Serial bank mapper package
// Field widths, access codes and the bank state bundle.
// ---------------------------------------------------------------------------
package sbm_pkg;

  localparam int REQ_W    = 2;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int TGT_W    = 2;
  localparam int MADDR_W  = 18;
  localparam int MIRROR_W = 2;
  localparam int CFG_W    = 5;
  localparam int SHIFT_W  = 5;
  localparam int CNT_W    = 3;
  localparam int PRG_W    = 4;
  localparam int CHR_W    = 5;

  localparam logic [CNT_W-1:0]    SHIFT_LAST       = 3'd4;
  localparam logic [CFG_W-1:0]    PRG_BANKS_RESET  = 5'd16;
  localparam logic [MIRROR_W-1:0] MIRROR_RESET     = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CPU_RD = 2'd0,
    REQ_CPU_WR = 2'd1,
    REQ_PPU_RD = 2'd2,
    REQ_PPU_WR = 2'd3
  } req_type_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_PRG_RAM = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_CHR     = 2'd2,
    TGT_REG     = 2'd3
  } target_t;

  // Register picked by address bits 14..13 of the fifth serial write.
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } reg_sel_t;

  typedef enum logic {
    CFG_PRG_ROM_BANKS = 1'b0,
    CFG_INIT_MIRROR   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [MIRROR_W-1:0] mirror;
    logic                slot_high;
    logic                prg_32k;
    logic                chr_4k;
    logic [CHR_W-1:0]    chr_lo;
    logic [CHR_W-1:0]    chr_hi;
    logic [PRG_W-1:0]    prg_bank;
    logic [PRG_W-1:0]    last_bank;
  } bank_state_t;

  typedef struct packed {
    logic     en;
    logic     reset_shift;
    logic     bit_in;
    reg_sel_t sel;
  } map_wr_t;

endpackage

// ----- hdl/sbm_if.sv -----
// ---------------------------------------------------------------------------
// Serial bank mapper channels
// Access request channel and mapped result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sbm_req_if;
  import sbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input address, input write_data,
                  output ready);
endinterface

interface sbm_rsp_if;
  import sbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TGT_W-1:0]    target;
  logic [MADDR_W-1:0]  mapped_address;
  logic                write_strobe;
  logic [MIRROR_W-1:0] mirroring;

  modport source (output valid, output target, output mapped_address,
                  output write_strobe, output mirroring, input ready);
  modport sink   (input valid, input target, input mapped_address,
                  input write_strobe, input mirroring, output ready);
endinterface

// ----- hdl/sbm_map.sv -----
// ---------------------------------------------------------------------------
// Serial bank mapper address decode
// Map one access to target memory, byte offset and strobe; form mapper writes.
// ---------------------------------------------------------------------------
module sbm_map (
  input  logic [sbm_pkg::REQ_W-1:0]   req_type,
  input  logic [sbm_pkg::ADDR_W-1:0]  address,
  input  logic [sbm_pkg::DATA_W-1:0]  write_data,
  input  sbm_pkg::bank_state_t        bank,
  output sbm_pkg::target_t            target,
  output logic [sbm_pkg::MADDR_W-1:0] mapped_address,
  output logic                        write_strobe,
  output sbm_pkg::map_wr_t            wr
);
  import sbm_pkg::*;

  req_type_t          req;
  logic [MADDR_W-1:0] prg_addr;
  logic [MADDR_W-1:0] chr_addr;

  assign req = req_type_t'(req_type);

  // PRG ROM: 32K mode drops bank bit 0; 16K mode fixes one slot.
  always_comb begin
    if (bank.prg_32k) begin
      prg_addr = {bank.prg_bank[PRG_W-1:1], address[14:0]};
    end else if (!address[14]) begin
      prg_addr = bank.slot_high ? {bank.prg_bank, address[13:0]}
                                : {{PRG_W{1'b0}}, address[13:0]};
    end else begin
      prg_addr = bank.slot_high ? {bank.last_bank, address[13:0]}
                                : {bank.prg_bank, address[13:0]};
    end
  end

  // CHR: two 4K banks or one 8K bank.
  always_comb begin
    if (bank.chr_4k) begin
      chr_addr = address[12] ? {1'b0, bank.chr_hi, address[11:0]}
                             : {1'b0, bank.chr_lo, address[11:0]};
    end else begin
      chr_addr = {1'b0, bank.chr_lo[CHR_W-1:1], address[12:0]};
    end
  end

  always_comb begin
    target         = TGT_PRG_RAM;
    mapped_address = '0;
    write_strobe   = 1'b0;
    wr.en          = 1'b0;
    wr.reset_shift = write_data[7];
    wr.bit_in      = write_data[0];
    wr.sel         = reg_sel_t'(address[14:13]);
    unique case (req)
      REQ_CPU_RD, REQ_CPU_WR: begin
        if (!address[15]) begin
          target         = TGT_PRG_RAM;
          mapped_address = {5'd0, address[12:0]};
          write_strobe   = (req == REQ_CPU_WR);
        end else if (req == REQ_CPU_RD) begin
          target         = TGT_PRG_ROM;
          mapped_address = prg_addr;
        end else begin
          target = TGT_REG;
          wr.en  = 1'b1;
        end
      end
      REQ_PPU_RD, REQ_PPU_WR: begin
        target         = TGT_CHR;
        mapped_address = chr_addr;
        write_strobe   = (req == REQ_PPU_WR);
      end
      default: begin
        target = TGT_PRG_RAM;
      end
    endcase
  end

endmodule

// ----- hdl/sbm_state.sv -----
// ---------------------------------------------------------------------------
// Serial bank mapper state
// Configuration, five-bit serial load and the bank registers it fills.
// ---------------------------------------------------------------------------
`include "serial_bank_mapper_mmc1_defines.svh"

module sbm_state (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [sbm_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         commit,
  input  sbm_pkg::map_wr_t             wr,
  output sbm_pkg::bank_state_t         bank,
  output logic [sbm_pkg::MIRROR_W-1:0] mirror_nxt
);
  import sbm_pkg::*;

  logic [CFG_W-1:0]    prg_rom_banks_r;
  logic [SHIFT_W-1:0]  shift_bits_r, shift_bits_nxt;
  logic [CNT_W-1:0]    shift_count_r, shift_count_nxt;
  logic [MIRROR_W-1:0] mirror_r;
  logic                slot_high_r, slot_high_nxt;
  logic                prg_32k_r, prg_32k_nxt;
  logic                chr_4k_r, chr_4k_nxt;
  logic [CHR_W-1:0]    chr_lo_r, chr_lo_nxt;
  logic [CHR_W-1:0]    chr_hi_r, chr_hi_nxt;
  logic [PRG_W-1:0]    prg_bank_r, prg_bank_nxt;
  logic [SHIFT_W-1:0]  shifted;
  logic [CFG_W-1:0]    last_full;

  assign shifted   = shift_bits_r | (SHIFT_W'(wr.bit_in) << shift_count_r);
  assign last_full = prg_rom_banks_r - 5'd1;

  always_comb begin
    shift_bits_nxt  = shift_bits_r;
    shift_count_nxt = shift_count_r;
    mirror_nxt      = mirror_r;
    slot_high_nxt   = slot_high_r;
    prg_32k_nxt     = prg_32k_r;
    chr_4k_nxt      = chr_4k_r;
    chr_lo_nxt      = chr_lo_r;
    chr_hi_nxt      = chr_hi_r;
    prg_bank_nxt    = prg_bank_r;
    if (commit && wr.en) begin
      if (wr.reset_shift) begin
        shift_bits_nxt  = '0;
        shift_count_nxt = '0;
        prg_32k_nxt     = 1'b0;
        slot_high_nxt   = 1'b1;
      end else if (shift_count_r == SHIFT_LAST) begin
        // fifth bit: load the selected register and restart the shift
        shift_bits_nxt  = '0;
        shift_count_nxt = '0;
        unique case (wr.sel)
          SEL_CONTROL: begin
            mirror_nxt    = shifted[1:0];
            slot_high_nxt = shifted[2];
            prg_32k_nxt   = !shifted[3];
            chr_4k_nxt    = shifted[4];
          end
          SEL_CHR0: chr_lo_nxt   = shifted;
          SEL_CHR1: chr_hi_nxt   = shifted;
          SEL_PRG:  prg_bank_nxt = shifted[PRG_W-1:0];
          default:  prg_bank_nxt = prg_bank_r;
        endcase
      end else begin
        shift_bits_nxt  = shifted;
        shift_count_nxt = shift_count_r + 3'd1;
      end
    end else if (cfg_wr_en && cfg_idx_t'(cfg_index) == CFG_INIT_MIRROR) begin
      mirror_nxt = cfg_wr_data[MIRROR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_rom_banks_r <= PRG_BANKS_RESET;
      shift_bits_r    <= '0;
      shift_count_r   <= '0;
      mirror_r        <= MIRROR_RESET;
      slot_high_r     <= 1'b1;
      prg_32k_r       <= 1'b0;
      chr_4k_r        <= 1'b0;
      chr_lo_r        <= '0;
      chr_hi_r        <= '0;
      prg_bank_r      <= '0;
    end else begin
      if (cfg_wr_en && cfg_idx_t'(cfg_index) == CFG_PRG_ROM_BANKS) begin
        prg_rom_banks_r <= cfg_wr_data;
      end
      shift_bits_r  <= shift_bits_nxt;
      shift_count_r <= shift_count_nxt;
      mirror_r      <= mirror_nxt;
      slot_high_r   <= slot_high_nxt;
      prg_32k_r     <= prg_32k_nxt;
      chr_4k_r      <= chr_4k_nxt;
      chr_lo_r      <= chr_lo_nxt;
      chr_hi_r      <= chr_hi_nxt;
      prg_bank_r    <= prg_bank_nxt;
    end
  end

  assign bank.mirror    = mirror_r;
  assign bank.slot_high = slot_high_r;
  assign bank.prg_32k   = prg_32k_r;
  assign bank.chr_4k    = chr_4k_r;
  assign bank.chr_lo    = chr_lo_r;
  assign bank.chr_hi    = chr_hi_r;
  assign bank.prg_bank  = prg_bank_r;
  assign bank.last_bank = last_full[PRG_W-1:0];

  `SBM_ASSERT(a_cnt_range, shift_count_r <= SHIFT_LAST)
  `SBM_ASSERT(a_clear,
              commit && wr.en && wr.reset_shift
              |=> shift_count_r == '0 && slot_high_r && !prg_32k_r)
  `SBM_ASSERT(a_load_restart,
              commit && wr.en && !wr.reset_shift && shift_count_r == SHIFT_LAST
              |=> shift_bits_r == '0 && shift_count_r == '0)

endmodule

// ----- hdl/serial_bank_mapper_mmc1.sv -----
// ---------------------------------------------------------------------------
// Serial bank mapper, top level
// Input register, address decode with serial register load, result register.
// ---------------------------------------------------------------------------
//  port      dir   handshake     payload
//  in_ch     in    valid/ready   req_type, address, write_data
//  out_ch    out   valid/ready   target, mapped_address, write_strobe, mirroring
//  cfg_*     in    cfg_wr_en     cfg_index, cfg_wr_data (no read-back)
//
//  One item per cycle sustained while out_ch.ready holds; each item passes
//  the input register, then decode and mapper state update into the result
//  register. Reset is synchronous; there is no clearing pass.
//  A stalled result holds in the result register; one more item waits in the
//  input register, then in_ch.ready drops until out_ch.ready returns.
// ---------------------------------------------------------------------------
`include "serial_bank_mapper_mmc1_defines.svh"

module serial_bank_mapper_mmc1 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [sbm_pkg::CFG_W-1:0] cfg_wr_data,
  sbm_req_if.sink                   in_ch,
  sbm_rsp_if.source                 out_ch
);
  import sbm_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [REQ_W-1:0]  s1_req_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // result register
  logic                out_valid_r;
  logic [TGT_W-1:0]    out_target_r;
  logic [MADDR_W-1:0]  out_maddr_r;
  logic                out_strobe_r;
  logic [MIRROR_W-1:0] out_mirror_r;

  logic                advance;
  bank_state_t         bank;
  map_wr_t             wr;
  target_t             map_target;
  logic [MADDR_W-1:0]  map_maddr;
  logic                map_strobe;
  logic [MIRROR_W-1:0] mirror_nxt;

  // Advance the held item when the result slot is empty or being drained.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r  <= in_ch.req_type;
      s1_addr_r <= in_ch.address;
      s1_data_r <= in_ch.write_data;
    end
  end

  // Decode against the bank state as it stands before this item.
  sbm_map u_map (
    .req_type       (s1_req_r),
    .address        (s1_addr_r),
    .write_data     (s1_data_r),
    .bank           (bank),
    .target         (map_target),
    .mapped_address (map_maddr),
    .write_strobe   (map_strobe),
    .wr             (wr)
  );

  // Commit the mapper write as the item moves into the result register.
  sbm_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .commit      (advance),
    .wr          (wr),
    .bank        (bank),
    .mirror_nxt  (mirror_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Mirroring reported is the value after this item's mapper write.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_target_r <= map_target;
      out_maddr_r  <= map_maddr;
      out_strobe_r <= map_strobe;
      out_mirror_r <= mirror_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.target         = out_target_r;
  assign out_ch.mapped_address = out_maddr_r;
  assign out_ch.write_strobe   = out_strobe_r;
  assign out_ch.mirroring      = out_mirror_r;

  `SBM_ASSERT(a_adv_fills, advance |=> out_valid_r)
  `SBM_ASSERT(a_reg_quiet,
              out_valid_r && out_target_r == TGT_REG |-> out_maddr_r == '0 && !out_strobe_r)
  `SBM_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule
